// ===== design/pid_controller_with_options_top_defines.svh =====
// Assertion macros shared by the PID controller checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef PID_CONTROLLER_WITH_OPTIONS_TOP_DEFINES_SVH
`define PID_CONTROLLER_WITH_OPTIONS_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

`endif

// ===== design/pidc_pkg.sv =====
// Shared types, codes and fixed-point helpers for the PID controller.
// No dependencies; imported by the arithmetic unit and the top level.
`default_nettype none
package pidc_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_STALL, S_ERR, S_P, S_I1, S_I2, S_D1, S_D2, S_VR_CHK, S_VR1,
        S_VR2, S_DF_A, S_DF_M1, S_DF_M2, S_CLAMP, S_SUM, S_OF_A, S_OF_M1,
        S_OF_M2, S_FIN
    } pidc_state_t;

    localparam logic [2:0] CFG_GAIN_P       = 3'd0;
    localparam logic [2:0] CFG_GAIN_I       = 3'd1;
    localparam logic [2:0] CFG_GAIN_D       = 3'd2;
    localparam logic [2:0] CFG_OUTPUT_LIMIT = 3'd3;
    localparam logic [2:0] CFG_BAND_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_INTEGRAL_CAP = 3'd5;
    localparam logic [2:0] CFG_OPTION_BITS  = 3'd6;

    localparam int unsigned OPT_STALL   = 0;
    localparam int unsigned OPT_TRAP    = 1;
    localparam int unsigned OPT_VRATE   = 2;
    localparam int unsigned OPT_DMEAS   = 3;
    localparam int unsigned OPT_DFILT   = 4;
    localparam int unsigned OPT_ICLAMP  = 5;
    localparam int unsigned OPT_OFILT   = 6;

    // Request to the shared multiply / divide unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] num;
        logic [39:0] den;
    } pidc_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } pidc_rsp_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Magnitude plus sign back to a saturated signed 32-bit value.
    function automatic logic signed [31:0] from_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m >= 64'h8000_0000)
                from_mag = 32'sh8000_0000;
            else
                from_mag = -$signed(m[31:0]);
        end else begin
            if (m > 64'h7FFF_FFFF)
                from_mag = 32'sh7FFF_FFFF;
            else
                from_mag = $signed(m[31:0]);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic same_sign(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        same_sign = (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

endpackage
`default_nettype wire

// ===== design/pidc_arith.sv =====
// Shared arithmetic unit: registered 32x32 multiply, 64/40 restoring divide.
// Depends on pidc_pkg for the request and response structs.
`default_nettype none
module pidc_arith
    import pidc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pidc_req_t req,
    output pidc_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [39:0] rem_reg, rem_next;
    logic [39:0] den_reg, den_next;

    logic [40:0] shifted;
    logic [40:0] diff;
    logic        fits;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            if (req.is_div) begin
                q_next    = req.num;
                rem_next  = '0;
                den_next  = req.den;
                cnt_next  = 6'd63;
                busy_next = 1'b1;
            end else begin
                q_next    = 64'(req.num[31:0]) * 64'(req.den[31:0]);
                done_next = 1'b1;
            end
        end else if (busy_reg) begin
            q_next   = {q_reg[62:0], fits};
            rem_next = fits ? diff[39:0] : shifted[39:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;

endmodule
`default_nettype wire

// ===== design/pid_controller_with_options_top.sv =====
// Positional PID controller with dead band, filters, anti-windup and stall flag.
// One request at a time: a sample inside the dead band skips the multiply and
// divide steps on the shared unit. The next request is taken once the result is
// registered; the result waits in the sequencer while an earlier one is not taken.
// Reset clears config to defaults, all history and the stall flag.
`default_nettype none
module pid_controller_with_options_top
    import pidc_pkg::*;
#(
    parameter int OUT_FILTER_RC   = 655,
    parameter int DERIV_FILTER_RC = 655,
    parameter int RATE_SPAN_A     = 65536,
    parameter int RATE_FLOOR_B    = 65536,
    parameter int STALL_LIMIT     = 500
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] measured,
    input  wire logic signed [31:0] target,
    input  wire logic [31:0]        elapsed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      drive,
    output logic                    stalled,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam logic [32:0] RATE_SUM = 33'(RATE_SPAN_A) + 33'(RATE_FLOOR_B);
    localparam logic [39:0] DF_DEN0  = 40'(DERIV_FILTER_RC) << 8;
    localparam logic [39:0] OF_DEN0  = 40'(OUT_FILTER_RC) << 8;

    // Configuration registers
    logic [30:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0] output_limit_reg, band_width_reg, integral_cap_reg;
    logic [6:0]  option_bits_reg;

    // History kept between requests
    logic signed [31:0] prev_measured_reg, prev_measured_next;
    logic signed [31:0] prev_target_reg, prev_target_next;
    logic signed [31:0] prev_error_reg, prev_error_next;
    logic signed [31:0] integral_sum_reg, integral_sum_next;
    logic signed [31:0] prev_drive_reg, prev_drive_next;
    logic signed [31:0] prev_derivative_reg, prev_derivative_next;
    logic [9:0]         stall_count_reg, stall_count_next;
    logic               stall_flag_reg, stall_flag_next;

    // Sequencer and working registers
    pidc_state_t        state_reg, state_next;
    logic               pend_reg, pend_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] tgt_reg, tgt_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] pterm_reg, pterm_next;
    logic signed [31:0] iterm_reg, iterm_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [31:0] isum_reg, isum_next;
    logic signed [31:0] drv_reg, drv_next;
    logic signed [31:0] t_reg, t_next;
    logic [24:0]        alpha_reg, alpha_next;
    logic signed [63:0] acc_reg, acc_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] drive_out_reg, drive_out_next;
    logic               stalled_out_reg, stalled_out_next;

    pidc_req_t req;
    pidc_rsp_t rsp;

    pidc_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Combinational helpers
    logic signed [32:0] e_diff, s_half, d_meas, d_err, ti, sd;
    logic signed [33:0] to;
    logic [32:0]        s_mag, sd_mag, to_mag;
    logic signed [31:0] err_calc, half, ibase, dsrc;
    logic [31:0]        ae, pd_mag, ar;
    logic signed [31:0] lim_s, cap_s, newint;
    logic signed [63:0] lp_term, lp_sum;
    logic [63:0]        lp_mag;
    logic signed [31:0] lp_val;
    logic [9:0]         cnt_upd;
    logic               out_free;

    always_comb
    begin
        e_diff   = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
        err_calc = sat32(64'(e_diff));
        s_half   = {err_reg[31], err_reg} + {prev_error_reg[31], prev_error_reg};
        s_mag    = s_half[32] ? 33'(-s_half) : 33'(s_half);
        half     = from_mag(64'(s_mag) >> 1, s_half[32]);
        ibase    = option_bits_reg[OPT_TRAP] ? half : err_reg;
        d_meas   = {prev_measured_reg[31], prev_measured_reg} - {meas_reg[31], meas_reg};
        d_err    = {err_reg[31], err_reg} - {prev_error_reg[31], prev_error_reg};
        dsrc     = option_bits_reg[OPT_DMEAS] ? sat32(64'(d_meas)) : sat32(64'(d_err));
        ae       = mag32(err_reg);
        lim_s    = $signed({1'b0, output_limit_reg});
        cap_s    = $signed({1'b0, integral_cap_reg});
        ti       = 33'(isum_reg) + 33'(iterm_reg);
        to       = 34'(pterm_reg) + 34'(isum_reg) + 34'(deriv_reg);
        to_mag   = to[33] ? 33'(-to) : 33'(to);
        newint   = sat32(64'(isum_reg) + 64'(iterm_reg));
        // Second half of a low-pass: add the older sample's weighted term.
        lp_term  = (state_reg == S_DF_M2 ? prev_derivative_reg[31] : prev_drive_reg[31])
                   ? -$signed(rsp.result) : $signed(rsp.result);
        lp_sum   = acc_reg + lp_term;
        lp_mag   = lp_sum[63] ? 64'(-lp_sum) : 64'(lp_sum);
        lp_val   = from_mag(lp_mag >> 24, lp_sum[63]);
        // Stall check on the previous sample
        pd_mag   = mag32(prev_drive_reg);
        ar       = mag32(prev_target_reg);
        sd       = {prev_target_reg[31], prev_target_reg}
                   - {prev_measured_reg[31], prev_measured_reg};
        sd_mag   = sd[32] ? 33'(-sd) : 33'(sd);
        out_free = !out_valid_reg || out_ready;
        if (38'(sd_mag) * 38'd20 > 38'(ar) * 38'd19)
            cnt_upd = (stall_count_reg == 10'd1023) ? stall_count_reg
                                                     : stall_count_reg + 10'd1;
        else
            cnt_upd = '0;
    end

    // Sequencer
    always_comb
    begin
        state_next           = state_reg;
        pend_next            = pend_reg;
        meas_next            = meas_reg;
        tgt_next             = tgt_reg;
        dt_next              = dt_reg;
        err_next             = err_reg;
        pterm_next           = pterm_reg;
        iterm_next           = iterm_reg;
        deriv_next           = deriv_reg;
        isum_next            = isum_reg;
        drv_next             = drv_reg;
        t_next               = t_reg;
        alpha_next           = alpha_reg;
        acc_next             = acc_reg;
        prev_measured_next   = prev_measured_reg;
        prev_target_next     = prev_target_reg;
        prev_error_next      = prev_error_reg;
        integral_sum_next    = integral_sum_reg;
        prev_drive_next      = prev_drive_reg;
        prev_derivative_next = prev_derivative_reg;
        stall_count_next     = stall_count_reg;
        stall_flag_next      = stall_flag_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        drive_out_next       = drive_out_reg;
        stalled_out_next     = stalled_out_reg;
        req                  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the request; a zero interval counts as one time unit.
                if (in_valid) begin
                    meas_next  = measured;
                    tgt_next   = target;
                    dt_next    = (elapsed == 32'd0) ? 32'd1 : elapsed;
                    state_next = option_bits_reg[OPT_STALL] ? S_STALL : S_ERR;
                end
            end
            S_STALL:
            begin
                // Skip when the last drive or reference was too small to judge.
                if (!(42'(pd_mag) * 42'd1000 < 42'(output_limit_reg)
                      || 46'(ar) * 46'd10000 < 46'd65536)) begin
                    stall_count_next = cnt_upd;
                    if (cnt_upd > 10'(STALL_LIMIT))
                        stall_flag_next = 1'b1;
                end
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next  = err_calc;
                isum_next = integral_sum_reg;
                if (mag32(err_calc) > 32'(band_width_reg)) begin
                    state_next = S_P;
                end else begin
                    // Inside the dead band: zero output and integral.
                    drv_next          = '0;
                    integral_sum_next = '0;
                    deriv_next        = prev_derivative_reg;
                    state_next        = S_FIN;
                end
            end
            S_P:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(err_reg));
                req.den   = 40'(gain_p_reg);
                if (rsp.done) begin
                    pterm_next = from_mag(rsp.result >> 16, err_reg[31]);
                    state_next = S_I1;
                end
            end
            S_I1:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(ibase));
                req.den   = 40'(gain_i_reg);
                if (rsp.done) begin
                    t_next     = from_mag(rsp.result >> 16, ibase[31]);
                    state_next = S_I2;
                end
            end
            S_I2:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(t_reg));
                req.den   = 40'(dt_reg);
                if (rsp.done) begin
                    iterm_next = from_mag(rsp.result >> 24, t_reg[31]);
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(dsrc));
                req.den   = 40'(gain_d_reg);
                if (rsp.done) begin
                    t_next     = from_mag(rsp.result >> 16, dsrc[31]);
                    state_next = S_D2;
                end
            end
            S_D2:
            begin
                // Rate of change: scaled difference over the interval.
                req.start  = !pend_reg;
                req.is_div = 1'b1;
                req.num    = {8'd0, mag32(t_reg), 24'd0};
                req.den    = 40'(dt_reg);
                if (rsp.done) begin
                    deriv_next = from_mag(rsp.result, t_reg[31]);
                    state_next = S_VR_CHK;
                end
            end
            S_VR_CHK:
            begin
                state_next = option_bits_reg[OPT_DFILT] ? S_DF_A : S_CLAMP;
                if (option_bits_reg[OPT_VRATE] && same_sign(err_reg, integral_sum_reg)
                    && 33'(ae) > 33'(RATE_FLOOR_B)) begin
                    if (RATE_SPAN_A > 0 && 33'(ae) <= RATE_SUM)
                        state_next = S_VR1;
                    else
                        iterm_next = '0;
                end
            end
            S_VR1:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(iterm_reg));
                req.den   = 40'(RATE_SUM - 33'(ae));
                if (rsp.done) begin
                    acc_next   = $signed(rsp.result);
                    state_next = S_VR2;
                end
            end
            S_VR2:
            begin
                req.start  = !pend_reg;
                req.is_div = 1'b1;
                req.num    = acc_reg;
                req.den    = 40'(RATE_SPAN_A);
                if (rsp.done) begin
                    iterm_next = from_mag(rsp.result, iterm_reg[31]);
                    state_next = option_bits_reg[OPT_DFILT] ? S_DF_A : S_CLAMP;
                end
            end
            S_DF_A, S_OF_A:
            begin
                // Filter weight from the interval and the time constant.
                req.start  = !pend_reg;
                req.is_div = 1'b1;
                req.num    = {8'd0, dt_reg, 24'd0};
                req.den    = ((state_reg == S_DF_A) ? DF_DEN0 : OF_DEN0) + 40'(dt_reg);
                if (rsp.done) begin
                    alpha_next = rsp.result[24:0];
                    state_next = (state_reg == S_DF_A) ? S_DF_M1 : S_OF_M1;
                end
            end
            S_DF_M1:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(deriv_reg));
                req.den   = 40'(alpha_reg);
                if (rsp.done) begin
                    acc_next   = deriv_reg[31] ? -$signed(rsp.result) : $signed(rsp.result);
                    state_next = S_DF_M2;
                end
            end
            S_DF_M2:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(prev_derivative_reg));
                req.den   = 40'(25'h100_0000 - alpha_reg);
                if (rsp.done) begin
                    deriv_next = lp_val;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                // Anti-windup, when enabled: hold the integral when saturated and clamp it to the cap.
                if (option_bits_reg[OPT_ICLAMP]) begin
                    if (to_mag > 33'(output_limit_reg) && same_sign(err_reg, isum_reg))
                        iterm_next = '0;
                    if (ti > 33'(cap_s)) begin
                        iterm_next = '0;
                        isum_next  = cap_s;
                    end
                    if (ti < -33'(cap_s)) begin
                        iterm_next = '0;
                        isum_next  = -cap_s;
                    end
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                integral_sum_next = newint;
                drv_next   = sat32(64'(pterm_reg) + 64'(newint) + 64'(deriv_reg));
                state_next = option_bits_reg[OPT_OFILT] ? S_OF_A : S_FIN;
            end
            S_OF_M1:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(drv_reg));
                req.den   = 40'(alpha_reg);
                if (rsp.done) begin
                    acc_next   = drv_reg[31] ? -$signed(rsp.result) : $signed(rsp.result);
                    state_next = S_OF_M2;
                end
            end
            S_OF_M2:
            begin
                req.start = !pend_reg;
                req.num   = 64'(mag32(prev_drive_reg));
                req.den   = 40'(25'h100_0000 - alpha_reg);
                if (rsp.done) begin
                    drv_next   = lp_val;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Clamp, retire the sample into history and present the result.
                if (out_free) begin
                    if (drv_reg > lim_s)
                        drive_out_next = lim_s;
                    else if (drv_reg < -lim_s)
                        drive_out_next = -lim_s;
                    else
                        drive_out_next = drv_reg;
                    out_valid_next       = 1'b1;
                    stalled_out_next     = stall_flag_reg;
                    prev_measured_next   = meas_reg;
                    prev_target_next     = tgt_reg;
                    prev_error_next      = err_reg;
                    prev_drive_next      = drive_out_next;
                    prev_derivative_next = deriv_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (req.start)
            pend_next = 1'b1;
        if (rsp.done)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg           <= S_IDLE;
            pend_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
            stalled_out_reg     <= 1'b0;
            prev_measured_reg   <= '0;
            prev_target_reg     <= '0;
            prev_error_reg      <= '0;
            integral_sum_reg    <= '0;
            prev_drive_reg      <= '0;
            prev_derivative_reg <= '0;
            stall_count_reg     <= '0;
            stall_flag_reg      <= 1'b0;
            gain_p_reg          <= '0;
            gain_i_reg          <= '0;
            gain_d_reg          <= '0;
            output_limit_reg    <= 31'h7FFF_FFFF;
            band_width_reg      <= '0;
            integral_cap_reg    <= 31'h7FFF_FFFF;
            option_bits_reg     <= '0;
        end else begin
            state_reg           <= state_next;
            pend_reg            <= pend_next;
            out_valid_reg       <= out_valid_next;
            stalled_out_reg     <= stalled_out_next;
            prev_measured_reg   <= prev_measured_next;
            prev_target_reg     <= prev_target_next;
            prev_error_reg      <= prev_error_next;
            integral_sum_reg    <= integral_sum_next;
            prev_drive_reg      <= prev_drive_next;
            prev_derivative_reg <= prev_derivative_next;
            stall_count_reg     <= stall_count_next;
            stall_flag_reg      <= stall_flag_next;
            // Writes beyond the register list are dropped.
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GAIN_P:       gain_p_reg       <= cfg_data[30:0];
                    CFG_GAIN_I:       gain_i_reg       <= cfg_data[30:0];
                    CFG_GAIN_D:       gain_d_reg       <= cfg_data[30:0];
                    CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data[30:0];
                    CFG_BAND_WIDTH:   band_width_reg   <= cfg_data[30:0];
                    CFG_INTEGRAL_CAP: integral_cap_reg <= cfg_data[30:0];
                    CFG_OPTION_BITS:  option_bits_reg  <= cfg_data[6:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg      <= meas_next;
        tgt_reg       <= tgt_next;
        dt_reg        <= dt_next;
        err_reg       <= err_next;
        pterm_reg     <= pterm_next;
        iterm_reg     <= iterm_next;
        deriv_reg     <= deriv_next;
        isum_reg      <= isum_next;
        drv_reg       <= drv_next;
        t_reg         <= t_next;
        alpha_reg     <= alpha_next;
        acc_reg       <= acc_next;
        drive_out_reg <= drive_out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_out_reg;
    assign stalled   = stalled_out_reg;

endmodule
`default_nettype wire

// ===== design/pidc_checker.sv =====
// Port-level checker for the PID controller, bound to the top level.
// Depends on the assertion macros header.
`default_nettype none
`include "pid_controller_with_options_top_defines.svh"
module pidc_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] drive,
    input wire logic               stalled
);

    // One request in flight: ready drops right after a request is taken.
    `PIDC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    // A waiting result is held until taken.
    `PIDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive))
    // The stall flag is sticky until reset.
    `PIDC_ASSERT_NEXT(a_stall_sticky, stalled, stalled)
    // The symmetric clamp never reaches the most negative code.
    `PIDC_ASSERT_SAME(a_drive_sym, out_valid, drive != 32'sh8000_0000)

endmodule

bind pid_controller_with_options_top pidc_checker u_pidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .stalled   (stalled)
);
`default_nettype wire
